@@ rtl/core/playback_drift_balance_core_assert.svh @@
// Assertion macros for the playback drift balance core.
// Depends on clk_i and rst_ni being present in the module that includes it.
`ifndef PLAYBACK_DRIFT_BALANCE_CORE_ASSERT_SVH
`define PLAYBACK_DRIFT_BALANCE_CORE_ASSERT_SVH

// Property checked on the rising clock edge, skipped while reset is low.
`define PDB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same form, kept apart for checks that also hold while reset is low.
`define PDB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/pdb_pkg.sv @@
// Package for the playback drift balance core: state and mode types,
// register indexes and reset values. No dependencies.
package pdb_pkg;

  localparam int FracBitsDef = 30;
  localparam int FillBitsDef = 16;

  localparam int RatioW = 32;
  localparam int FieldW = 16;
  localparam int ProdW  = 2 * RatioW;
  localparam int CntW   = $clog2(RatioW);

  localparam logic [1:0] CfgFillHigh  = 2'd0;
  localparam logic [1:0] CfgFillLow   = 2'd1;
  localparam logic [1:0] CfgHoldCount = 2'd2;

  localparam logic [FieldW-1:0] FillHighRst  = 16'd256;
  localparam logic [FieldW-1:0] FillLowRst   = 16'd160;
  localparam logic [FieldW-1:0] HoldCountRst = 16'd3000;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SLOW   = 2'd1,
    MODE_FAST   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_STEP,
    ST_MUL_CLK,
    ST_DONE
  } state_e;

endpackage

@@ rtl/core/playback_drift_balance_core.sv @@
// Playback drift balance core: balance-ratio controller with a bit-serial multiplier.
// Depends on pdb_pkg and playback_drift_balance_core_assert.svh.
//
//   channel   direction  tdata / payload                         tuser
//   s_axis    in         fill_level, clock_ratio                 op
//   m_axis    out        balance, resample, reload, mode         -
//   cfg       in         cfg_index_i, cfg_data_i                 -
//
// A report is taken in IDLE, its control decision is made in the DECIDE state,
// and every product goes through a shift-and-add multiplier that retires one
// multiplier bit per cycle. A report that enters an excursion with a ratio
// step needs two products; every other report needs one. The output word
// sits in a register of its own, so the next report is taken while a finished
// word still waits on m_axis_tready.
// Reset restores the registers to their documented defaults, the mode to
// normal, both hold counters to zero and the ratio to 1.0.
`include "playback_drift_balance_core_assert.svh"

module playback_drift_balance_core #(
  parameter int FRAC_BITS = pdb_pkg::FracBitsDef,
  parameter int FILL_BITS = pdb_pkg::FillBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input reports.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // fill_level [15:0], clock_ratio [47:16]
  input  logic        s_axis_tuser,   // op: 0 fill report, 1 underrun
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // balance_ratio [31:0], resample_ratio [63:32], ratio_reload [64],
  // balance_mode [66:65], zero fill [71:67]
  output logic [71:0] m_axis_tdata,
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int RW = pdb_pkg::RatioW;
  localparam int FW = pdb_pkg::FieldW;
  localparam int PW = pdb_pkg::ProdW;
  localparam int CW = pdb_pkg::CntW;

  // Fixed-point constants, rounded to nearest at FRAC_BITS.
  localparam logic [63:0] OneQ       = 64'd1 << FRAC_BITS;
  localparam logic [63:0] StepDelta  = (OneQ * 64'd5 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] UpStep     = OneQ + StepDelta;
  localparam logic [63:0] DownStep   = OneQ - StepDelta;
  localparam logic [63:0] HighTarget = OneQ + (OneQ * 64'd5 + 64'd500) / 64'd1000;
  localparam logic [63:0] LowTarget  = OneQ - (OneQ * 64'd5 + 64'd5000) / 64'd10000;

  localparam logic [RW-1:0] One32  = OneQ[RW-1:0];
  localparam logic [RW-1:0] Up32   = UpStep[RW-1:0];
  localparam logic [RW-1:0] Down32 = DownStep[RW-1:0];
  localparam logic [RW-1:0] High32 = HighTarget[RW-1:0];
  localparam logic [RW-1:0] Low32  = LowTarget[RW-1:0];

  // Fill levels keep only FILL_BITS bits.
  localparam logic [FW-1:0] FillMask =
    (FILL_BITS >= FW) ? {FW{1'b1}} : FW'((32'd1 << FILL_BITS) - 32'd1);

  localparam logic [CW-1:0] LastBit = CW'(RW - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes drop.
  // ---------------------------------------------------------------------------
  logic [FW-1:0] fill_high_q, fill_low_q, hold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_high_q <= pdb_pkg::FillHighRst;
      fill_low_q  <= pdb_pkg::FillLowRst;
      hold_q      <= pdb_pkg::HoldCountRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pdb_pkg::CfgFillHigh:  fill_high_q <= cfg_data_i;
        pdb_pkg::CfgFillLow:   fill_low_q  <= cfg_data_i;
        pdb_pkg::CfgHoldCount: hold_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  pdb_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q;
  logic            do_mul;      // excursion entry needs a ratio step product
  logic            mul_last;
  logic            out_free;

  assign mul_last = (cnt_q == LastBit);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pdb_pkg::ST_IDLE:     if (s_axis_tvalid) state_d = pdb_pkg::ST_DECIDE;
      pdb_pkg::ST_DECIDE:   state_d = do_mul ? pdb_pkg::ST_MUL_STEP : pdb_pkg::ST_MUL_CLK;
      pdb_pkg::ST_MUL_STEP: if (mul_last) state_d = pdb_pkg::ST_MUL_CLK;
      pdb_pkg::ST_MUL_CLK:  if (mul_last) state_d = pdb_pkg::ST_DONE;
      pdb_pkg::ST_DONE:     if (out_free) state_d = pdb_pkg::ST_IDLE;
      default:              state_d = pdb_pkg::ST_IDLE;
    endcase
  end

  logic mul_run, out_load;

  always_comb begin
    s_axis_tready = 1'b0;
    mul_run       = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      pdb_pkg::ST_IDLE:     s_axis_tready = 1'b1;
      pdb_pkg::ST_MUL_STEP,
      pdb_pkg::ST_MUL_CLK:  mul_run = 1'b1;
      pdb_pkg::ST_DONE:     out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Captured report.
  // ---------------------------------------------------------------------------
  logic          op_q;
  logic [FW-1:0] fill_q;
  logic [RW-1:0] clock_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= s_axis_tuser;
      fill_q  <= s_axis_tdata[15:0] & FillMask;
      clock_q <= s_axis_tdata[47:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Control decision, made in the DECIDE cycle.
  // ---------------------------------------------------------------------------
  pdb_pkg::mode_e mode_q, mode_d;
  logic [FW-1:0]  slow_q, slow_d, fast_q, fast_d;
  logic [RW-1:0]  ratio_q, ratio_d;
  logic           reload_q, reload_d;
  logic [RW-1:0]  step_mult;

  logic          above, below;
  logic [RW-1:0] target;
  logic [RW+2:0] avg_sum;
  logic [RW-1:0] avg;
  logic [FW-1:0] slow_inc, fast_inc;
  logic          done;

  assign above = (fill_q > fill_high_q);
  assign below = (fill_q < fill_low_q);
  // Only a fill report below the band averages toward the low target.
  assign target   = (!op_q && !above && below) ? Low32 : High32;
  assign avg_sum  = {3'b000, ratio_q} + {2'b00, ratio_q, 1'b0} + {3'b000, target};
  assign avg      = avg_sum[RW+1:2];
  assign slow_inc = slow_q + 1'b1;
  assign fast_inc = fast_q + 1'b1;

  always_comb begin
    mode_d    = mode_q;
    slow_d    = slow_q;
    fast_d    = fast_q;
    ratio_d   = ratio_q;
    reload_d  = 1'b0;
    do_mul    = 1'b0;
    step_mult = Up32;
    done      = 1'b0;
    if (op_q) begin
      // Underrun: fast slow-down, capped at the high target.
      ratio_d  = (avg < High32) ? avg : High32;
      mode_d   = pdb_pkg::MODE_SLOW;
      slow_d   = FW'(1);
      fast_d   = '0;
      reload_d = 1'b1;
    end else if (above) begin
      if (slow_q == '0) begin
        case (mode_q)
          pdb_pkg::MODE_NORMAL,
          pdb_pkg::MODE_SLOW: begin
            do_mul    = 1'b1;
            step_mult = Up32;
          end
          pdb_pkg::MODE_FAST: ratio_d = One32;
          default: ;
        endcase
        mode_d   = pdb_pkg::MODE_SLOW;
        slow_d   = FW'(1);
        fast_d   = '0;
        reload_d = 1'b1;
      end else if (slow_inc == hold_q) begin
        slow_d = FW'(1);
        if (ratio_q != High32) ratio_d = avg;
      end else begin
        slow_d = slow_inc;
      end
    end else if (below) begin
      if (fast_q == '0) begin
        case (mode_q)
          pdb_pkg::MODE_NORMAL,
          pdb_pkg::MODE_FAST: begin
            do_mul    = 1'b1;
            step_mult = Down32;
          end
          pdb_pkg::MODE_SLOW: ratio_d = One32;
          default: ;
        endcase
        mode_d   = pdb_pkg::MODE_FAST;
        fast_d   = FW'(1);
        slow_d   = '0;
        reload_d = 1'b1;
      end else if (fast_inc >= hold_q) begin
        fast_d = FW'(1);
        if (ratio_q != Low32) ratio_d = avg;
      end else begin
        fast_d = fast_inc;
      end
    end else begin
      // Inside the band: the fast counter does not advance once the slow
      // counter has reached the hold count.
      if (slow_q != '0) begin
        slow_d = slow_inc;
        done   = (slow_inc == hold_q);
      end
      if (!done && fast_q != '0) begin
        fast_d = fast_inc;
        done   = (fast_inc == hold_q);
      end
      if (done) begin
        mode_d = pdb_pkg::MODE_NORMAL;
        slow_d = '0;
        fast_d = '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Bit-serial multiplier: one multiplier bit per cycle, LSB first. The upper
  // half of the accumulator takes the add, then the whole word shifts right.
  // ---------------------------------------------------------------------------
  logic [RW-1:0] mcand_q, mplier_q;
  logic [PW-1:0] acc_q;
  logic [RW:0]   part_sum;
  logic [PW-1:0] acc_nx;
  logic [PW-1:0] prod_shr;
  logic [RW-1:0] prod_sat;

  assign part_sum = {1'b0, acc_q[PW-1:RW]} + (mplier_q[0] ? {1'b0, mcand_q} : '0);
  assign acc_nx   = {part_sum, acc_q[RW-1:1]};
  assign prod_shr = acc_nx >> FRAC_BITS;
  assign prod_sat = (|prod_shr[PW-1:RW]) ? {RW{1'b1}} : prod_shr[RW-1:0];

  logic [RW-1:0] res_q;

  always_ff @(posedge clk_i) begin
    if (state_q == pdb_pkg::ST_DECIDE) begin
      acc_q    <= '0;
      cnt_q    <= '0;
      mcand_q  <= do_mul ? ratio_q : clock_q;
      mplier_q <= do_mul ? step_mult : ratio_d;
    end else if (mul_run) begin
      if (mul_last && state_q == pdb_pkg::ST_MUL_STEP) begin
        // Ratio step done; the clock product follows with the new ratio.
        acc_q    <= '0;
        cnt_q    <= '0;
        mcand_q  <= clock_q;
        mplier_q <= prod_sat;
      end else begin
        acc_q    <= acc_nx;
        cnt_q    <= cnt_q + 1'b1;
        mplier_q <= mplier_q >> 1;
      end
      if (mul_last && state_q == pdb_pkg::ST_MUL_CLK) res_q <= prod_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= pdb_pkg::MODE_NORMAL;
      slow_q   <= '0;
      fast_q   <= '0;
      ratio_q  <= One32;
      reload_q <= 1'b0;
    end else if (state_q == pdb_pkg::ST_DECIDE) begin
      mode_q   <= mode_d;
      slow_q   <= slow_d;
      fast_q   <= fast_d;
      reload_q <= reload_d;
      if (!do_mul) ratio_q <= ratio_d;
    end else if (state_q == pdb_pkg::ST_MUL_STEP && mul_last) begin
      ratio_q <= prod_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic [71:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= {5'b00000, mode_q, reload_q, res_q, ratio_q};
    end
  end

  assign m_axis_tdata = out_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `PDB_ASSERT(a_accept_decides,
    (s_axis_tvalid && s_axis_tready) |=> (state_q == pdb_pkg::ST_DECIDE),
    "accepted report did not move to the decision cycle")
  `PDB_ASSERT(a_idle_ratio_stable,
    (state_q == pdb_pkg::ST_IDLE) |=> $stable(ratio_q),
    "balance ratio changed while idle")
  `PDB_ASSERT(a_one_counter,
    !(slow_q != '0 && fast_q != '0),
    "both hold counters running")
  `PDB_ASSERT(a_normal_counters,
    (mode_q == pdb_pkg::MODE_NORMAL) |-> (slow_q == '0 && fast_q == '0),
    "normal mode with a hold counter running")
  `PDB_ASSERT_ALWAYS(a_word_from_done,
    $rose(m_axis_tvalid) |-> $past(state_q == pdb_pkg::ST_DONE),
    "result word shown without a finished item")

endmodule
